@@ hdl/bia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and constants for the bitmap ID allocator: request and
// response payloads, request codes and the limit register reset value.
// ----------------------------------------------------------------------------
package bia_pkg;

    // Width of an ID and of the limit register
    localparam int ID_W = 11;

    // Smallest ID handed out; position p stands for ID p + MIN_ID
    localparam int MIN_ID = 1;

    // Reset value of the limit register
    localparam logic [ID_W-1:0] LIMIT_RESET = 11'd1024;

    // Request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Request transaction
    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] release_id;
    } t_req;

    // Response transaction
    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            pool_full;
    } t_rsp;

endpackage

@@ hdl/bia_word_find.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_word_find
// Finds the lowest clear bit of one map word whose position lies below the
// effective limit. Purely combinational; used once per scanned word.
// ----------------------------------------------------------------------------
module bia_word_find #(
    parameter int WORD_BITS = 32,
    parameter int BASE_W    = 12
) (
    input  logic [WORD_BITS-1:0]         i_word,
    input  logic [BASE_W-1:0]            i_base,
    input  logic [bia_pkg::ID_W-1:0]     i_limit,
    output logic                         o_hit,
    output logic [$clog2(WORD_BITS)-1:0] o_bit
);
    import bia_pkg::*;

    localparam int BIT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] w_elig;

    // Flag bits that are free and inside the managed range
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_elig[b] = !i_word[b] && ((i_base + BASE_W'(b)) < BASE_W'(i_limit));
        end
    end

    // Pick the lowest flagged bit
    always_comb begin
        o_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_elig[b]) begin
                o_bit = BIT_W'(b);
            end
        end
    end

    assign o_hit = |w_elig;

endmodule

@@ hdl/bitmap_id_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Next-fit ID allocator over a used-bit map held in a word memory. Allocate
// scans words cyclically from the word of the last grant; release clears the
// bit of an in-range ID and returns nothing.
//
//   channel   direction  signals                          handshake
//   request   in         i_req_valid o_req_ready i_req    valid/ready
//   response  out        o_rsp_valid i_rsp_ready o_rsp    valid/ready
//   config    in         i_cfg_we i_cfg_data              write enable
//
// Allocate: accept, wrap the start word into the words in use, then scan
// one word per cycle, at most ceil(limit/WORD_BITS) words. Release: accept,
// then update the map word; an out-of-range release is only accepted and
// changes nothing.
// After reset a clearing pass writes all NUM_WORDS words, one per cycle, then
// a sizing pass runs; a limit write while idle or sizing repeats the sizing
// pass. Requests are not taken during either pass.
// A new request is taken no earlier than the edge at which the last result
// leaves the response register.
// ----------------------------------------------------------------------------
module bitmap_id_allocator #(
    parameter int MAX_IDS   = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  bia_pkg::t_req            i_req,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output bia_pkg::t_rsp            o_rsp,
    input  logic                     i_cfg_we,
    input  logic [bia_pkg::ID_W-1:0] i_cfg_data
);
    import bia_pkg::*;

    localparam int NUM_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WCNT_W    = $clog2(NUM_WORDS + 1);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SUM_W     = $clog2((2 ** ID_W) + 2 * WORD_BITS);
    localparam int CAP       = (MAX_IDS < (2 ** ID_W)) ? MAX_IDS : (2 ** ID_W) - 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_SIZE  = 6'b000010,
        S_IDLE  = 6'b000100,
        S_MOD   = 6'b001000,
        S_CHK   = 6'b010000,
        S_RMW   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [ID_W-1:0]     r_limit, n_limit;
    logic [WIDX-1:0]     r_w, n_w;
    logic [SUM_W-1:0]    r_base, n_base;
    logic [SUM_W-1:0]    r_span, n_span;
    logic [WCNT_W-1:0]   r_words, n_words;
    logic [WCNT_W-1:0]   r_cnt, n_cnt;
    logic [ID_W-1:0]     r_rem, n_rem;
    logic [WIDX-1:0]     r_last_w, n_last_w;
    logic [SUM_W-1:0]    r_last_base, n_last_base;
    logic                r_rsp_valid, n_rsp_valid;
    t_rsp                r_rsp, n_rsp;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic                 wr_en;
    logic [WIDX-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [ID_W-1:0]      lim;
    logic                 find_hit;
    logic [BIT_W-1:0]     find_bit;
    logic [WORD_BITS-1:0] hit_mask;
    logic [WORD_BITS-1:0] rel_mask;
    logic [SUM_W-1:0]     next_base;
    logic                 req_acc;
    logic                 rel_in_range;

    // Clamp the limit register into one through the pool size
    always_comb begin
        if (r_limit == '0) begin
            lim = ID_W'(MIN_ID);
        end else if (int'(r_limit) > CAP) begin
            lim = ID_W'(CAP);
        end else begin
            lim = r_limit;
        end
    end

    // Search the word under scan
    bia_word_find #(
        .WORD_BITS (WORD_BITS),
        .BASE_W    (SUM_W)
    ) u_find (
        .i_word  (r_rdata),
        .i_base  (r_base),
        .i_limit (lim),
        .o_hit   (find_hit),
        .o_bit   (find_bit)
    );

    always_comb begin
        hit_mask           = '0;
        hit_mask[find_bit] = 1'b1;
        rel_mask                   = '0;
        rel_mask[r_rem[BIT_W-1:0]] = 1'b1;
    end

    assign next_base    = r_base + SUM_W'(WORD_BITS);
    assign o_req_ready  = (r_state == S_IDLE) && !i_cfg_we && (!r_rsp_valid || i_rsp_ready);
    assign req_acc      = i_req_valid && o_req_ready;
    assign rel_in_range = (i_req.release_id >= ID_W'(MIN_ID)) && (i_req.release_id <= lim);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_w         = r_w;
        n_base      = r_base;
        n_span      = r_span;
        n_words     = r_words;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_last_w    = r_last_w;
        n_last_base = r_last_base;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        wr_en       = 1'b0;
        wr_addr     = r_w;
        wr_data     = '0;

        // Drop the response once taken
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_w == WIDX'(NUM_WORDS - 1)) begin
                    n_w     = '0;
                    n_state = S_SIZE;
                    n_span  = '0;
                    n_words = '0;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_SIZE: begin
                // Count the words in use: step until the span covers the limit
                if (r_span < SUM_W'(lim)) begin
                    n_span  = r_span + SUM_W'(WORD_BITS);
                    n_words = r_words + 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_w     = r_last_w;
                        n_base  = r_last_base;
                        n_state = S_MOD;
                    end else if (rel_in_range) begin
                        // Split the position into word and bit
                        n_rem   = i_req.release_id - ID_W'(MIN_ID);
                        n_w     = WIDX'(n_rem >> BIT_W);
                        n_state = S_RMW;
                    end
                end
            end
            S_MOD: begin
                // Wrap the start word into the words in use
                if (WCNT_W'(r_w) >= r_words) begin
                    n_w    = r_w - WIDX'(r_words);
                    n_base = r_base - r_span;
                end else begin
                    n_cnt   = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (find_hit) begin
                    wr_en       = 1'b1;
                    wr_data     = r_rdata | hit_mask;
                    n_last_w    = r_w;
                    n_last_base = r_base;
                    n_rsp_valid = 1'b1;
                    n_rsp.granted_id = ID_W'(r_base + SUM_W'(find_bit) + SUM_W'(MIN_ID));
                    n_rsp.pool_full  = 1'b0;
                    n_state     = S_IDLE;
                end else if (r_cnt + 1'b1 == r_words) begin
                    n_rsp_valid = 1'b1;
                    n_rsp.granted_id = '0;
                    n_rsp.pool_full  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    // Advance to the next word, wrapping at the span
                    n_cnt = r_cnt + 1'b1;
                    if (next_base >= r_span) begin
                        n_w    = '0;
                        n_base = '0;
                    end else begin
                        n_w    = r_w + 1'b1;
                        n_base = next_base;
                    end
                end
            end
            S_RMW: begin
                wr_en   = 1'b1;
                wr_data = r_rdata & ~rel_mask;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Take a limit write; resize only when idle or sizing
        if (i_cfg_we) begin
            n_limit = i_cfg_data;
            if (r_state == S_IDLE || r_state == S_SIZE) begin
                n_state = S_SIZE;
                n_span  = '0;
                n_words = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_limit     <= LIMIT_RESET;
            r_w         <= '0;
            r_span      <= '0;
            r_words     <= '0;
            r_cnt       <= '0;
            r_last_w    <= '0;
            r_last_base <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_w         <= n_w;
            r_span      <= n_span;
            r_words     <= n_words;
            r_cnt       <= n_cnt;
            r_last_w    <= n_last_w;
            r_last_base <= n_last_base;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_rem  <= n_rem;
        r_rsp  <= n_rsp;
    end

    // Map memory: one write port, registered read at the next word index
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[n_w];
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
